/* hdl/lz77td_pkg.sv */
`default_nettype none

package lz77td_pkg;

  localparam int HISTORY_DEPTH    = 65536;
  localparam int BYTES_PER_RESULT = 4;

  localparam int OFFSET_W = 16;
  localparam int LENGTH_W = 8;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 3;

  // four byte fields per result; packing width clamped to 1..LANES
  localparam int LANES  = 4;
  localparam int LANE_W = (BYTES_PER_RESULT < 1) ? 1 :
                          ((BYTES_PER_RESULT > LANES) ? LANES : BYTES_PER_RESULT);
  localparam int FILL_W = $clog2(LANES);

  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int PROD_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CALC_W = ((PROD_W > OFFSET_W) ? PROD_W : OFFSET_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

/* hdl/lz77td_ram.sv */
`default_nettype none

module lz77td_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write to the same address returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/lz77_token_decompressor.sv */
`default_nettype none

// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// token    | token_valid / token_stall  | match_offset, match_length, literal_byte
// result   | result_valid / result_stall| byte_0..byte_3, byte_count, is_last, bad_token
//
// Literal, error and empty tokens load the result on accept when can_load, else they
// wait in ST_EMIT; a copy issues RAM reads and writes back one byte per cycle unless stalled.
// Reset (rst, synchronous) clears state, result_valid, wp, produced, pend and fwd and
// holds token_stall high; the history RAM is not cleared, reads stay on written slots.
// A result due while the result register is full and stalled freezes the copy.
// A new token is taken while the last result of the previous one still waits.

module lz77_token_decompressor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              token_valid,
  output logic                              token_stall,
  input  logic [lz77td_pkg::OFFSET_W-1:0]   match_offset,
  input  logic [lz77td_pkg::LENGTH_W-1:0]   match_length,
  input  logic [lz77td_pkg::BYTE_W-1:0]     literal_byte,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [lz77td_pkg::BYTE_W-1:0]     byte_0,
  output logic [lz77td_pkg::BYTE_W-1:0]     byte_1,
  output logic [lz77td_pkg::BYTE_W-1:0]     byte_2,
  output logic [lz77td_pkg::BYTE_W-1:0]     byte_3,
  output logic [lz77td_pkg::COUNT_W-1:0]    byte_count,
  output logic                              is_last,
  output logic                              bad_token
);

  import lz77td_pkg::*;

  localparam logic [CALC_W-1:0] DEPTH_C = CALC_W'(HISTORY_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_MAX = PTR_W'(HISTORY_DEPTH - 1);

  state_t state, state_next;

  // history pointers
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  wp_inc;
  logic [PROD_W-1:0] produced;

  // copy pipeline
  logic [PTR_W-1:0]    raddr;
  logic [PTR_W-1:0]    raddr_inc;
  logic [LENGTH_W-1:0] rcnt;      // reads still to issue
  logic [LENGTH_W-1:0] dcnt;      // bytes still to write back
  logic                pend;      // RAM data from the last issued read
  logic                fwd;       // that read hit the slot written in the same cycle
  logic [BYTE_W-1:0]   fwd_byte;
  logic [BYTE_W-1:0]   lane [LANES];
  logic [FILL_W-1:0]   fill;
  logic [COUNT_W-1:0]  hold_cnt;
  logic                hold_bad;

  // RAM port
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  // token decode
  logic [CALC_W-1:0] off_ext;
  logic [CALC_W-1:0] src_sum;
  logic [CALC_W-1:0] src_wrap;
  logic [PTR_W-1:0]  src_ptr;
  logic              is_lit;
  logic              is_bad;
  logic              is_copy;
  logic              accept;

  // per-cycle control
  logic               can_load;
  logic [BYTE_W-1:0]  copy_byte;
  logic [COUNT_W-1:0] fill_plus;
  logic               last_byte;
  logic               emit_need;
  logic               advance;
  logic [BYTE_W-1:0]  lane_upd [LANES];

  // result register load
  logic               load_out;
  logic [BYTE_W-1:0]  ld_bytes [LANES];
  logic [COUNT_W-1:0] ld_cnt;
  logic               ld_last;
  logic               ld_bad;

  lz77td_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  assign token_stall = rst || (state != ST_IDLE);
  assign accept      = token_valid && !token_stall;
  assign can_load    = !result_valid || !result_stall;

  assign wp_inc    = (wp == PTR_MAX) ? '0 : wp + PTR_W'(1);
  assign raddr_inc = (raddr == PTR_MAX) ? '0 : raddr + PTR_W'(1);

  // offset check and copy source; offset up to depth maps back onto the ring
  always_comb begin
    off_ext  = CALC_W'(match_offset);
    is_lit   = (match_offset == '0) && (match_length == '0);
    is_bad   = !is_lit && ((match_offset == '0) || (off_ext > CALC_W'(produced)));
    is_copy  = !is_lit && !is_bad && (match_length != '0);
    src_sum  = CALC_W'(wp) + DEPTH_C - off_ext;
    src_wrap = (src_sum >= DEPTH_C) ? src_sum - DEPTH_C : src_sum;
    src_ptr  = src_wrap[PTR_W-1:0];
  end

  // overlap at distance one: the read and the write hit one slot in one cycle
  assign copy_byte = fwd ? fwd_byte : ram_rdata;
  assign fill_plus = COUNT_W'(fill) + COUNT_W'(1);
  assign last_byte = (dcnt == LENGTH_W'(1));
  assign emit_need = (state == ST_COPY) && pend &&
                     ((fill_plus == COUNT_W'(LANE_W)) || last_byte);
  assign advance   = !emit_need || can_load;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_upd[i] = lane[i];
    end
    lane_upd[fill] = copy_byte;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_copy) begin
            state_next = ST_COPY;
          end else if (!can_load) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_COPY: begin
        if (pend && advance && last_byte) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: RAM port and result load
  always_comb begin
    load_out  = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      ld_bytes[i] = '0;
    end
    ld_cnt    = '0;
    ld_last   = 1'b0;
    ld_bad    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wp;
    ram_wdata = copy_byte;
    ram_re    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && !is_copy) begin
          if (is_lit) begin
            ram_we    = 1'b1;
            ram_wdata = literal_byte;
          end
          load_out    = can_load;
          ld_bytes[0] = is_lit ? literal_byte : '0;
          ld_cnt      = is_lit ? COUNT_W'(1) : '0;
          ld_last     = 1'b1;
          ld_bad      = is_bad;
        end
      end
      ST_COPY: begin
        if (advance) begin
          ram_we = pend;
          ram_re = (rcnt != '0);
          if (emit_need) begin
            load_out = 1'b1;
            ld_bytes = lane_upd;
            ld_cnt   = fill_plus;
            ld_last  = last_byte;
          end
        end
      end
      ST_EMIT: begin
        load_out = can_load;
        ld_bytes = lane;
        ld_cnt   = hold_cnt;
        ld_last  = 1'b1;
        ld_bad   = hold_bad;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      wp           <= '0;
      produced     <= '0;
      pend         <= 1'b0;
      fwd          <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= load_out || (result_valid && result_stall);
      if (ram_we) begin
        wp <= wp_inc;
        if (produced != PROD_W'(HISTORY_DEPTH)) begin
          produced <= produced + PROD_W'(1);
        end
      end
      if ((state == ST_COPY) && advance) begin
        pend <= ram_re;
        fwd  <= ram_we && (wp == raddr);
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load_out) begin
      byte_0     <= ld_bytes[0];
      byte_1     <= ld_bytes[1];
      byte_2     <= ld_bytes[2];
      byte_3     <= ld_bytes[3];
      byte_count <= ld_cnt;
      is_last    <= ld_last;
      bad_token  <= ld_bad;
    end
    if (accept) begin
      if (is_copy) begin
        raddr <= src_ptr;
        rcnt  <= match_length;
        dcnt  <= match_length;
        fill  <= '0;
        for (int i = 0; i < LANES; i++) begin
          lane[i] <= '0;
        end
      end else if (!can_load) begin
        for (int i = 1; i < LANES; i++) begin
          lane[i] <= '0;
        end
        lane[0]  <= is_lit ? literal_byte : '0;
        hold_cnt <= is_lit ? COUNT_W'(1) : '0;
        hold_bad <= is_bad;
      end
    end
    if ((state == ST_COPY) && advance) begin
      fwd_byte <= copy_byte;
      if (ram_re) begin
        raddr <= raddr_inc;
        rcnt  <= rcnt - LENGTH_W'(1);
      end
      if (pend) begin
        dcnt <= dcnt - LENGTH_W'(1);
        if (emit_need) begin
          fill <= '0;
          for (int i = 0; i < LANES; i++) begin
            lane[i] <= '0;
          end
        end else begin
          fill <= fill + FILL_W'(1);
          lane <= lane_upd;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lz77td_chk.sv */
`default_nettype none

module lz77td_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [lz77td_pkg::BYTE_W-1:0]     byte_0,
  input logic [lz77td_pkg::BYTE_W-1:0]     byte_3,
  input logic [lz77td_pkg::COUNT_W-1:0]    byte_count,
  input logic                              is_last,
  input logic                              bad_token
);

  import lz77td_pkg::*;

  // an error result carries no bytes and closes its transaction
  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_token |-> (byte_count == '0) && is_last && (byte_0 == '0))
    else $error("error result with data or not last");

  // only the final result of a token may be short
  a_mid_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_last |-> (byte_count == COUNT_W'(LANE_W)) && !bad_token)
    else $error("non-final result not fully packed");

  // unused byte lanes read as zero; only byte_3 is checked
  a_lane_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (byte_count != COUNT_W'(LANES)) |-> (byte_3 == '0))
    else $error("byte_3 nonzero beyond count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(byte_0) &&
    $stable(byte_count) && $stable(is_last) && $stable(bad_token))
    else $error("stalled result changed");

endmodule

bind lz77_token_decompressor lz77td_chk u_lz77td_chk (.*);

`default_nettype wire
